// ----- hdl/jsu_pkg.sv -----
`timescale 1ns / 1ps

package jsu_pkg;

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_BODY,
      PH_ESC,
      PH_HEX1,
      PH_BSL,
      PH_EXU,
      PH_HEX2
   } phase_type;

   typedef enum logic [3:0] {
      ERR_NONE      = 4'd0,
      ERR_NO_QUOTE  = 4'd1,
      ERR_CONTROL   = 4'd2,
      ERR_BAD_ESC   = 4'd3,
      ERR_BAD_HEX   = 4'd4,
      ERR_LONE_LOW  = 4'd5,
      ERR_NO_PAIR   = 4'd6,
      ERR_BAD_LOW   = 4'd7,
      ERR_TRUNCATED = 4'd8
   } err_type;

   localparam logic [7:0] CH_QUOTE  = 8'h22;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_U      = 8'h75;
   localparam logic [7:0] CH_DEL    = 8'h7F;

   localparam logic [5:0]  SURR_HI_TAG = 6'b110110;
   localparam logic [5:0]  SURR_LO_TAG = 6'b110111;
   localparam logic [20:0] SUPP_BASE   = 21'h10000;

   localparam logic [7:0] LEAD4 = 8'b11110000;
   localparam logic [7:0] LEAD3 = 8'b11100000;
   localparam logic [7:0] LEAD2 = 8'b11000000;
   localparam logic [7:0] CONT  = 8'b10000000;

   typedef struct packed {
      phase_type   phase;
      logic [15:0] hex_accum;
      logic [1:0]  hex_digits_seen;
      logic [9:0]  saved_high_bits;
   } state_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       byte_valid;
      logic       closed;
      err_type    error;
   } result_type;

   typedef struct packed {
      logic [2:0]            count;
      result_type [3:0]      results;
   } bundle_type;

   // {valid, nibble}
   function automatic logic [4:0] hex_value(input logic [7:0] c);
      logic [4:0] r;
      r = 5'd0;
      if (c >= 8'h30 && c <= 8'h39) begin
         r = {1'b1, c[3:0]};
      end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
         r = {1'b1, c[3:0] + 4'd9};
      end
      return r;
   endfunction

   // {valid, character} for single-character escapes
   function automatic logic [8:0] simple_escape(input logic [7:0] c);
      logic [8:0] r;
      case (c)
         8'h6E:   r = {1'b1, 8'h0A};
         8'h74:   r = {1'b1, 8'h09};
         8'h72:   r = {1'b1, 8'h0D};
         8'h62:   r = {1'b1, 8'h08};
         8'h66:   r = {1'b1, 8'h0C};
         8'h22:   r = {1'b1, 8'h22};
         8'h2F:   r = {1'b1, 8'h2F};
         8'h5C:   r = {1'b1, 8'h5C};
         default: r = 9'd0;
      endcase
      return r;
   endfunction

endpackage

// ----- hdl/json_string_unescape_utf8.sv -----
`timescale 1ns / 1ps

// Channel  Direction  Ports                                      Transaction
// req      in         req_in_byte, req_start_req,                one raw byte
//                     req_end_of_buffer
// rsp      out        rsp_out_byte, rsp_byte_valid, rsp_last,    one result
//                     rsp_closed, rsp_error
//
// Each byte is decoded in the cycle it is accepted; its 0 to 4 results are
// registered and leave one per cycle while rsp_ready is high. The result
// buffer sets the rate: a new byte is taken when the buffer is empty or its
// final result leaves that cycle.
// Synchronous reset returns the decoder to idle and empties the buffer.

module json_string_unescape_utf8 (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_in_byte,
   input  logic       req_start_req,
   input  logic       req_end_of_buffer,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_byte_valid,
   output logic       rsp_last,
   output logic       rsp_closed,
   output logic [3:0] rsp_error
);
   import jsu_pkg::*;

   state_type  state_ff, state_in;
   bundle_type bundle_ff, bundle_in, bundle_new;
   logic       valid_ff, valid_in;
   logic [1:0] idx_ff, idx_in;
   logic       at_last;
   logic       req_take;
   result_type cur;

   jsu_decode u_decode (
      .state         (state_ff),
      .in_byte       (req_in_byte),
      .start_req     (req_start_req),
      .end_of_buffer (req_end_of_buffer),
      .state_next    (state_in),
      .bundle        (bundle_new)
   );

   assign at_last   = ({1'b0, idx_ff} == (bundle_ff.count - 3'd1));
   assign req_ready = !valid_ff || (rsp_ready && at_last);
   assign req_take  = req_valid && req_ready;
   assign cur       = bundle_ff.results[idx_ff];

   assign rsp_valid      = valid_ff;
   assign rsp_out_byte   = cur.out_byte;
   assign rsp_byte_valid = cur.byte_valid;
   assign rsp_closed     = cur.closed;
   assign rsp_error      = cur.error;
   assign rsp_last       = at_last;

   always_comb begin
      valid_in  = valid_ff;
      idx_in    = idx_ff;
      bundle_in = bundle_ff;
      if (valid_ff && rsp_ready) begin
         if (at_last) valid_in = 1'b0;
         else idx_in = idx_ff + 2'd1;
      end
      if (req_take && bundle_new.count != 3'd0) begin
         valid_in  = 1'b1;
         idx_in    = 2'd0;
         bundle_in = bundle_new;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '{phase: PH_IDLE, hex_accum: '0, hex_digits_seen: '0,
                       saved_high_bits: '0};
         valid_ff <= 1'b0;
         idx_ff   <= 2'd0;
      end else begin
         if (req_take) state_ff <= state_in;
         valid_ff <= valid_in;
         idx_ff   <= idx_in;
      end
      bundle_ff <= bundle_in;
   end

endmodule

// ----- hdl/jsu_decode.sv -----
`timescale 1ns / 1ps

module jsu_decode (
   input  jsu_pkg::state_type  state,
   input  logic [7:0]          in_byte,
   input  logic                start_req,
   input  logic                end_of_buffer,
   output jsu_pkg::state_type  state_next,
   output jsu_pkg::bundle_type bundle
);
   import jsu_pkg::*;

   logic [4:0]  hex;
   logic [8:0]  esc;
   logic [15:0] accum_new;
   logic        digits_done;
   logic        is_hi;
   logic        is_lo;
   logic        ctrl;
   logic        ignore;
   logic        closed;
   logic        finish;
   err_type     err;
   logic [20:0] cp_pair;

   assign hex         = hex_value(in_byte);
   assign esc         = simple_escape(in_byte);
   assign accum_new   = {state.hex_accum[11:0], hex[3:0]};
   assign digits_done = (state.hex_digits_seen == 2'd3);
   assign is_hi       = (accum_new[15:10] == SURR_HI_TAG);
   assign is_lo       = (accum_new[15:10] == SURR_LO_TAG);
   assign ctrl        = (in_byte < 8'h20) || (in_byte == CH_DEL);
   assign ignore      = !start_req && (state.phase == PH_IDLE);
   assign closed      = !start_req && (state.phase == PH_BODY) && !ctrl
                        && (in_byte == CH_QUOTE);
   assign finish      = (err != ERR_NONE) || closed || (end_of_buffer && !ignore);
   assign cp_pair     = {1'b0, state.saved_high_bits, accum_new[9:0]} + SUPP_BASE;

   always_comb begin
      err = ERR_NONE;
      if (start_req) begin
         if (in_byte != CH_QUOTE) err = ERR_NO_QUOTE;
      end else begin
         case (state.phase)
            PH_BODY: if (ctrl) err = ERR_CONTROL;
            PH_ESC:  if (!esc[8] && in_byte != CH_U) err = ERR_BAD_ESC;
            PH_HEX1: begin
               if (!hex[4]) err = ERR_BAD_HEX;
               else if (digits_done && is_lo) err = ERR_LONE_LOW;
            end
            PH_HEX2: begin
               if (!hex[4]) err = ERR_BAD_HEX;
               else if (digits_done && !is_lo) err = ERR_BAD_LOW;
            end
            PH_BSL:  if (in_byte != CH_BSLASH) err = ERR_NO_PAIR;
            PH_EXU:  if (in_byte != CH_U) err = ERR_NO_PAIR;
            default: err = ERR_NONE;
         endcase
      end
   end

   // next state
   always_comb begin
      state_next = state;
      if (finish || ignore) begin
         state_next = '0;
         state_next.phase = PH_IDLE;
      end else if (start_req) begin
         state_next = '0;
         state_next.phase = PH_BODY;
      end else begin
         case (state.phase)
            PH_BODY: if (in_byte == CH_BSLASH) state_next.phase = PH_ESC;
            PH_ESC: begin
               if (in_byte == CH_U) begin
                  state_next.phase = PH_HEX1;
                  state_next.hex_accum = '0;
                  state_next.hex_digits_seen = '0;
               end else begin
                  state_next.phase = PH_BODY;
               end
            end
            PH_HEX1, PH_HEX2: begin
               if (digits_done) begin
                  state_next.hex_accum = '0;
                  state_next.hex_digits_seen = '0;
                  if (state.phase == PH_HEX1 && is_hi) begin
                     state_next.saved_high_bits = accum_new[9:0];
                     state_next.phase = PH_BSL;
                  end else begin
                     state_next.phase = PH_BODY;
                  end
               end else begin
                  state_next.hex_accum = accum_new;
                  state_next.hex_digits_seen = state.hex_digits_seen + 2'd1;
               end
            end
            PH_BSL: state_next.phase = PH_EXU;
            PH_EXU: begin
               state_next.phase = PH_HEX2;
               state_next.hex_accum = '0;
               state_next.hex_digits_seen = '0;
            end
            default: state_next.phase = PH_IDLE;
         endcase
      end
   end

   // results
   always_comb begin
      bundle = '0;
      for (int i = 0; i < 4; i++) begin
         bundle.results[i].byte_valid = 1'b1;
         bundle.results[i].error = ERR_NONE;
      end
      if (!start_req) begin
         case (state.phase)
            PH_BODY: begin
               if (in_byte != CH_BSLASH) begin
                  bundle.count = 3'd1;
                  bundle.results[0].out_byte = in_byte;
               end
            end
            PH_ESC: begin
               if (esc[8]) begin
                  bundle.count = 3'd1;
                  bundle.results[0].out_byte = esc[7:0];
               end
            end
            PH_HEX1: begin
               if (digits_done && !is_hi) begin
                  if (accum_new[15:7] == '0) begin
                     bundle.count = 3'd1;
                     bundle.results[0].out_byte = {1'b0, accum_new[6:0]};
                  end else if (accum_new[15:11] == '0) begin
                     bundle.count = 3'd2;
                     bundle.results[0].out_byte = LEAD2 | {3'b000, accum_new[10:6]};
                     bundle.results[1].out_byte = CONT | {2'b00, accum_new[5:0]};
                  end else begin
                     bundle.count = 3'd3;
                     bundle.results[0].out_byte = LEAD3 | {4'b0000, accum_new[15:12]};
                     bundle.results[1].out_byte = CONT | {2'b00, accum_new[11:6]};
                     bundle.results[2].out_byte = CONT | {2'b00, accum_new[5:0]};
                  end
               end
            end
            PH_HEX2: begin
               if (digits_done) begin
                  bundle.count = 3'd4;
                  bundle.results[0].out_byte = LEAD4 | {5'b00000, cp_pair[20:18]};
                  bundle.results[1].out_byte = CONT | {2'b00, cp_pair[17:12]};
                  bundle.results[2].out_byte = CONT | {2'b00, cp_pair[11:6]};
                  bundle.results[3].out_byte = CONT | {2'b00, cp_pair[5:0]};
               end
            end
            default: bundle.count = 3'd0;
         endcase
      end
      if (finish) begin
         bundle.count = 3'd1;
         bundle.results[0].out_byte = '0;
         bundle.results[0].byte_valid = 1'b0;
         bundle.results[0].closed = 1'b0;
         if (err != ERR_NONE) begin
            bundle.results[0].error = err;
         end else if (closed) begin
            bundle.results[0].closed = 1'b1;
         end else begin
            bundle.results[0].error = ERR_TRUNCATED;
         end
      end
   end

endmodule

// ----- verif/json_string_unescape_utf8_test.sv -----
`timescale 1ns / 1ps

module json_string_unescape_utf8_test;
   import jsu_pkg::*;

   localparam int RANDOM_ITEMS = 360;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int SEND_IDLE [4] = '{0, 77, 0, 29};
   localparam int RSP_STALL [4] = '{0, 0, 77, 29};

   typedef enum logic [1:0] {
      CHK_MODEL,
      CHK_NONE,
      CHK_ONE
   } row_check_type;

   typedef struct packed {
      logic [7:0]    in_byte;
      logic          start;
      logic          eob;
      row_check_type check;
      logic [7:0]    exp_byte;
      logic          exp_valid;
      logic          exp_closed;
      err_type       exp_error;
   } byte_item_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       byte_valid;
      logic       last;
      logic       closed;
      err_type    error;
   } byte_result_type;

   localparam byte_item_type DIRECTED_ROWS [28] = '{
      '{8'h00,     1'b0, 1'b1, CHK_NONE,  8'h00, 1'b0, 1'b0, ERR_NONE},
      '{"Q",       1'b1, 1'b0, CHK_ONE,   8'h00, 1'b0, 1'b0, ERR_NO_QUOTE},
      '{CH_QUOTE,  1'b1, 1'b0, CHK_NONE,  8'h00, 1'b0, 1'b0, ERR_NONE},
      '{8'hFF,     1'b0, 1'b0, CHK_ONE,   8'hFF, 1'b1, 1'b0, ERR_NONE},
      '{8'h00,     1'b0, 1'b0, CHK_ONE,   8'h00, 1'b0, 1'b0, ERR_CONTROL},
      '{CH_QUOTE,  1'b1, 1'b0, CHK_NONE,  8'h00, 1'b0, 1'b0, ERR_NONE},
      '{CH_BSLASH, 1'b0, 1'b0, CHK_NONE,  8'h00, 1'b0, 1'b0, ERR_NONE},
      '{CH_U,      1'b0, 1'b0, CHK_NONE,  8'h00, 1'b0, 1'b0, ERR_NONE},
      '{"0",       1'b0, 1'b0, CHK_NONE,  8'h00, 1'b0, 1'b0, ERR_NONE},
      '{"7",       1'b0, 1'b0, CHK_NONE,  8'h00, 1'b0, 1'b0, ERR_NONE},
      '{"f",       1'b0, 1'b0, CHK_NONE,  8'h00, 1'b0, 1'b0, ERR_NONE},
      '{"F",       1'b0, 1'b0, CHK_MODEL, 8'h00, 1'b0, 1'b0, ERR_NONE},
      '{CH_BSLASH, 1'b0, 1'b0, CHK_NONE,  8'h00, 1'b0, 1'b0, ERR_NONE},
      '{CH_U,      1'b0, 1'b0, CHK_NONE,  8'h00, 1'b0, 1'b0, ERR_NONE},
      '{"D",       1'b0, 1'b0, CHK_MODEL, 8'h00, 1'b0, 1'b0, ERR_NONE},
      '{"B",       1'b0, 1'b0, CHK_MODEL, 8'h00, 1'b0, 1'b0, ERR_NONE},
      '{"F",       1'b0, 1'b0, CHK_MODEL, 8'h00, 1'b0, 1'b0, ERR_NONE},
      '{"F",       1'b0, 1'b0, CHK_MODEL, 8'h00, 1'b0, 1'b0, ERR_NONE},
      '{CH_BSLASH, 1'b0, 1'b0, CHK_MODEL, 8'h00, 1'b0, 1'b0, ERR_NONE},
      '{CH_U,      1'b0, 1'b0, CHK_MODEL, 8'h00, 1'b0, 1'b0, ERR_NONE},
      '{"d",       1'b0, 1'b0, CHK_MODEL, 8'h00, 1'b0, 1'b0, ERR_NONE},
      '{"F",       1'b0, 1'b0, CHK_MODEL, 8'h00, 1'b0, 1'b0, ERR_NONE},
      '{"f",       1'b0, 1'b0, CHK_MODEL, 8'h00, 1'b0, 1'b0, ERR_NONE},
      '{"F",       1'b0, 1'b0, CHK_MODEL, 8'h00, 1'b0, 1'b0, ERR_NONE},
      '{CH_QUOTE,  1'b0, 1'b1, CHK_ONE,   8'h00, 1'b0, 1'b1, ERR_NONE},
      '{CH_QUOTE,  1'b1, 1'b1, CHK_ONE,   8'h00, 1'b0, 1'b0, ERR_TRUNCATED},
      '{CH_QUOTE,  1'b1, 1'b0, CHK_NONE,  8'h00, 1'b0, 1'b0, ERR_NONE},
      '{CH_DEL,    1'b0, 1'b1, CHK_ONE,   8'h00, 1'b0, 1'b0, ERR_CONTROL}
   };

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic [7:0] req_in_byte = 8'h00;
   logic       req_start_req = 1'b0;
   logic       req_end_of_buffer = 1'b0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic [7:0] rsp_out_byte;
   logic       rsp_byte_valid;
   logic       rsp_last;
   logic       rsp_closed;
   logic [3:0] rsp_error;

   json_string_unescape_utf8 u_top (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_in_byte       (req_in_byte),
      .req_start_req     (req_start_req),
      .req_end_of_buffer (req_end_of_buffer),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_out_byte      (rsp_out_byte),
      .rsp_byte_valid    (rsp_byte_valid),
      .rsp_last          (rsp_last),
      .rsp_closed        (rsp_closed),
      .rsp_error         (rsp_error)
   );

   // decoder mirror
   phase_type   dec_phase  = PH_IDLE;
   logic [15:0] dec_accum  = '0;
   logic [1:0]  dec_digits = '0;
   logic [9:0]  dec_high   = '0;

   byte_result_type step_out [$];
   byte_result_type expected_bytes [$];
   byte_item_type   str_items [$];
   byte_item_type   req_item;

   int send_idle_pct = 0;
   int rsp_stall_pct = 0;
   int cycle_count = 0;
   int failures = 0;
   int decoded_items = 0;
   int ignored_items = 0;
   int results_checked = 0;
   int closed_seen = 0;
   int errors_seen = 0;

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic void clear_decoder();
      dec_phase  = PH_IDLE;
      dec_accum  = '0;
      dec_digits = '0;
      dec_high   = '0;
   endfunction

   function automatic void post_byte(logic [7:0] b);
      step_out.insert(step_out.size(), byte_result_type'{b, 1'b1, 1'b0, 1'b0, ERR_NONE});
   endfunction

   function automatic void decode_item(byte_item_type it);
      logic [7:0]  b;
      err_type     fault;
      logic        close_seen;
      logic        hex_ok;
      logic [3:0]  nib;
      logic [20:0] cp;
      b = it.in_byte;
      fault = ERR_NONE;
      close_seen = 1'b0;
      hex_ok = 1'b0;
      nib = '0;
      step_out.delete();
      if (it.start) begin
         clear_decoder();
         if (b == CH_QUOTE) dec_phase = PH_BODY;
         else fault = ERR_NO_QUOTE;
      end else begin
         case (dec_phase)
            PH_BODY: begin
               if (b < 8'h20 || b == CH_DEL) fault = ERR_CONTROL;
               else if (b == CH_BSLASH) dec_phase = PH_ESC;
               else if (b == CH_QUOTE) close_seen = 1'b1;
               else post_byte(b);
            end
            PH_ESC: begin
               dec_phase = PH_BODY;
               case (b)
                  "n":       post_byte(8'h0A);
                  "t":       post_byte(8'h09);
                  "r":       post_byte(8'h0D);
                  "b":       post_byte(8'h08);
                  "f":       post_byte(8'h0C);
                  CH_QUOTE:  post_byte(CH_QUOTE);
                  "/":       post_byte("/");
                  CH_BSLASH: post_byte(CH_BSLASH);
                  CH_U: begin
                     dec_phase  = PH_HEX1;
                     dec_accum  = '0;
                     dec_digits = '0;
                  end
                  default:   fault = ERR_BAD_ESC;
               endcase
            end
            PH_HEX1, PH_HEX2: begin
               if (b >= "0" && b <= "9") begin
                  hex_ok = 1'b1;
                  nib = 4'(b - "0");
               end else if (b >= "a" && b <= "f") begin
                  hex_ok = 1'b1;
                  nib = 4'(b - "a" + 8'd10);
               end else if (b >= "A" && b <= "F") begin
                  hex_ok = 1'b1;
                  nib = 4'(b - "A" + 8'd10);
               end
               if (!hex_ok) begin
                  fault = ERR_BAD_HEX;
               end else begin
                  dec_accum = {dec_accum[11:0], nib};
                  if (dec_digits != 2'd3) begin
                     dec_digits = dec_digits + 2'd1;
                  end else begin
                     dec_digits = '0;
                     if (dec_phase == PH_HEX1) begin
                        if (dec_accum[15:10] == SURR_LO_TAG) begin
                           fault = ERR_LONE_LOW;
                        end else if (dec_accum[15:10] == SURR_HI_TAG) begin
                           dec_high  = dec_accum[9:0];
                           dec_phase = PH_BSL;
                        end else begin
                           if (dec_accum <= 16'h007F) begin
                              post_byte(dec_accum[7:0]);
                           end else if (dec_accum <= 16'h07FF) begin
                              post_byte(LEAD2 | {3'b0, dec_accum[10:6]});
                              post_byte(CONT | {2'b0, dec_accum[5:0]});
                           end else begin
                              post_byte(LEAD3 | {4'b0, dec_accum[15:12]});
                              post_byte(CONT | {2'b0, dec_accum[11:6]});
                              post_byte(CONT | {2'b0, dec_accum[5:0]});
                           end
                           dec_phase = PH_BODY;
                        end
                     end else if (dec_accum[15:10] != SURR_LO_TAG) begin
                        fault = ERR_BAD_LOW;
                     end else begin
                        cp = SUPP_BASE + 21'({dec_high, dec_accum[9:0]});
                        post_byte(LEAD4 | {5'b0, cp[20:18]});
                        post_byte(CONT | {2'b0, cp[17:12]});
                        post_byte(CONT | {2'b0, cp[11:6]});
                        post_byte(CONT | {2'b0, cp[5:0]});
                        dec_phase = PH_BODY;
                     end
                     dec_accum = '0;
                  end
               end
            end
            PH_BSL: begin
               if (b == CH_BSLASH) dec_phase = PH_EXU;
               else fault = ERR_NO_PAIR;
            end
            PH_EXU: begin
               if (b == CH_U) begin
                  dec_phase  = PH_HEX2;
                  dec_accum  = '0;
                  dec_digits = '0;
               end else begin
                  fault = ERR_NO_PAIR;
               end
            end
            default: begin
               ignored_items++;
               return;
            end
         endcase
      end

      // fault beats close, close beats truncation
      if (fault != ERR_NONE || close_seen || it.eob) begin
         step_out.delete();
         step_out.insert(0, byte_result_type'{8'h00, 1'b0, 1'b0,
                              fault == ERR_NONE && close_seen,
                              fault != ERR_NONE ? fault :
                              (close_seen ? ERR_NONE : ERR_TRUNCATED)});
         clear_decoder();
      end
      if (step_out.size() > 0) step_out[step_out.size() - 1].last = 1'b1;

      decoded_items++;
      case (it.check)
         CHK_MODEL: foreach (step_out[i])
            expected_bytes.insert(expected_bytes.size(), step_out[i]);
         CHK_ONE:   expected_bytes.insert(expected_bytes.size(),
                       byte_result_type'{it.exp_byte, it.exp_valid, 1'b1,
                                         it.exp_closed, it.exp_error});
         default: ;
      endcase
   endfunction

   function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
      if (want !== got) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         failures++;
      end
   endfunction

   always @(posedge clock) begin
      byte_result_type want;
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("simulation failed");
         $finish;
      end else if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            results_checked++;
            if (rsp_closed) closed_seen++;
            if (rsp_error != ERR_NONE) errors_seen++;
            if (expected_bytes.size() == 0) begin
               $error("unexpected transaction: out_byte %0h error %0d", rsp_out_byte,
                      rsp_error);
               failures++;
            end else begin
               want = expected_bytes.pop_front();
               check_field("out_byte", want.out_byte, rsp_out_byte);
               check_field("byte_valid", 8'(want.byte_valid), 8'(rsp_byte_valid));
               check_field("last", 8'(want.last), 8'(rsp_last));
               check_field("closed", 8'(want.closed), 8'(rsp_closed));
               check_field("error", 8'(want.error), 8'(rsp_error));
            end
         end
         if (req_valid && req_ready) decode_item(req_item);
      end
   end

   always @(negedge clock) begin
      rsp_ready <= !reset && ($urandom_range(99) >= rsp_stall_pct);
   end

   task automatic send_item(byte_item_type it);
      int gap;
      gap = 0;
      if ($urandom_range(99) < send_idle_pct) gap = $urandom_range(1, 3);
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_item = it;
      req_valid <= 1'b1;
      req_in_byte <= it.in_byte;
      req_start_req <= it.start;
      req_end_of_buffer <= it.eob;
      do @(posedge clock); while (!req_ready);
   endtask

   function automatic void push_byte(logic [7:0] b, logic st);
      str_items.insert(str_items.size(),
                       byte_item_type'{b, st, 1'b0, CHK_MODEL, 8'h00, 1'b0, 1'b0,
                                       ERR_NONE});
   endfunction

   function automatic logic [7:0] hex_char(logic [3:0] n);
      if (n < 4'd10) return "0" + 8'(n);
      return ($urandom_range(1) ? "a" : "A") + 8'(n) - 8'd10;
   endfunction

   function automatic void push_unicode(logic [15:0] v);
      push_byte(CH_BSLASH, 1'b0);
      push_byte(CH_U, 1'b0);
      for (int i = 3; i >= 0; i--) push_byte(hex_char(v[i*4 +: 4]), 1'b0);
   endfunction

   // one string literal: mostly well formed, with occasional faults,
   // truncations, restarts and bytes sent while idle
   function automatic void build_string();
      int          tokens;
      int          pick;
      logic [7:0]  b;
      logic [15:0] cp;
      logic [15:0] high;
      str_items.delete();
      if ($urandom_range(19) == 0) push_byte(8'($urandom_range(255)), 1'b0);
      if ($urandom_range(19) == 0) push_byte(8'($urandom_range(255)), 1'b1);
      else push_byte(CH_QUOTE, 1'b1);
      tokens = $urandom_range(8);
      repeat (tokens) begin
         pick = $urandom_range(99);
         high = 16'hD800 | 16'($urandom_range(1023));
         if (pick < 47) begin
            do b = 8'($urandom_range(8'h20, 8'hFF));
            while (b == CH_QUOTE || b == CH_BSLASH || b == CH_DEL);
            push_byte(b, 1'b0);
         end else if (pick < 63) begin
            push_byte(CH_BSLASH, 1'b0);
            case ($urandom_range(7))
               0:       push_byte("n", 1'b0);
               1:       push_byte("t", 1'b0);
               2:       push_byte("r", 1'b0);
               3:       push_byte("b", 1'b0);
               4:       push_byte("f", 1'b0);
               5:       push_byte(CH_QUOTE, 1'b0);
               6:       push_byte("/", 1'b0);
               default: push_byte(CH_BSLASH, 1'b0);
            endcase
         end else if (pick < 77) begin
            case ($urandom_range(2))
               0:       cp = 16'($urandom_range(16'h007F));
               1:       cp = 16'($urandom_range(16'h0080, 16'h07FF));
               default: begin
                  do cp = 16'($urandom_range(16'h0800, 16'hFFFF));
                  while (cp >= 16'hD800 && cp <= 16'hDFFF);
               end
            endcase
            push_unicode(cp);
         end else if (pick < 94) begin
            push_unicode(high);
            push_unicode(16'hDC00 | 16'($urandom_range(1023)));
         end else begin
            case ($urandom_range(6))
               0: push_byte(8'($urandom_range(255)), 1'b0);
               1: begin
                  push_byte(CH_BSLASH, 1'b0);
                  push_byte(8'($urandom_range(255)), 1'b0);
               end
               2: begin
                  push_byte(CH_BSLASH, 1'b0);
                  push_byte(CH_U, 1'b0);
                  repeat ($urandom_range(3)) push_byte(hex_char(4'($urandom_range(15))), 1'b0);
                  push_byte(8'($urandom_range(255)), 1'b0);
               end
               3: push_unicode(16'hDC00 | 16'($urandom_range(1023)));
               4: begin
                  push_unicode(high);
                  push_byte(8'($urandom_range(255)), 1'b0);
               end
               5: begin
                  push_unicode(high);
                  push_byte(CH_BSLASH, 1'b0);
                  push_byte(8'($urandom_range(255)), 1'b0);
               end
               default: begin
                  push_unicode(high);
                  push_unicode(16'($urandom_range(16'hFFFF)));
               end
            endcase
         end
      end
      // an unclosed string gets restarted by the next one
      if ($urandom_range(14) != 0) push_byte(CH_QUOTE, 1'b0);
      foreach (str_items[i]) if ($urandom_range(59) == 0) str_items[i].eob = 1'b1;
   endfunction

   initial begin
      int target;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (DIRECTED_ROWS[i]) send_item(DIRECTED_ROWS[i]);

      target = decoded_items;
      for (int p = 0; p < 4; p++) begin
         send_idle_pct = SEND_IDLE[p];
         rsp_stall_pct = RSP_STALL[p];
         target += RANDOM_ITEMS / 4;
         while (decoded_items < target) begin
            build_string();
            foreach (str_items[i]) send_item(str_items[i]);
         end
      end
      @(negedge clock);
      req_valid <= 1'b0;

      while (expected_bytes.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);

      $display("%0d bytes decoded and %0d idle bytes skipped; %0d results checked",
               decoded_items, ignored_items, results_checked);
      $display("%0d strings closed, %0d ended on an error, over four pacing phases",
               closed_seen, errors_seen);
      if (failures == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
